@@ hdl/mtg_pkg.sv @@
// Shared types, constants and the control store for the multi-ant grid stepper.
// Used by the sequencer, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int DEF_ROWS     = 64;
  localparam int DEF_COLS     = 128;
  localparam int DEF_ANTS     = 16;
  localparam int RULE_ENTRIES = 512;
  localparam int CODE_W       = 9;
  localparam int MOVE_W       = 3;

  typedef enum logic [1:0] {
    CMD_RULE  = 2'd0,
    CMD_CELL  = 2'd1,
    CMD_PLACE = 2'd2,
    CMD_STEP  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    U_CLEAR,
    U_IDLE,
    U_RULE,
    U_CELL,
    U_PLACE,
    U_POS,
    U_NBR,
    U_LAST,
    U_MOVE
  } upc_t;

  typedef enum logic [2:0] {
    G_NONE,
    G_CLEAR,
    G_ITEM,
    G_NBR_RD,
    G_TOGGLE
  } grid_op_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_LOAD,
    R_READ
  } rule_op_t;

  typedef enum logic [1:0] {
    A_NONE,
    A_READ_IN,
    A_PLACE,
    A_MOVE
  } ant_op_t;

  typedef enum logic [2:0] {
    C_GOTO,
    C_DISPATCH,
    C_CLR,
    C_ANT_OK,
    C_KLAST,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    grid_op_t grid_op;
    rule_op_t rule_op;
    ant_op_t  ant_op;
    logic     pos_ld;
    logic     out_ld;
    logic     in_rdy;
    cond_t    cond;
    upc_t     target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    cmd_t cmd;
    logic clr_last;
    logic ant_ok;
    logic k_last;
    logic out_free;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    grid_op: G_NONE, rule_op: R_NONE, ant_op: A_NONE,
    pos_ld: 1'b0, out_ld: 1'b0, in_rdy: 1'b0,
    cond: C_GOTO, target: U_IDLE
  };

  function automatic ctrl_t ucode(input upc_t u);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (u)
      U_CLEAR: begin
        w.grid_op = G_CLEAR;
        w.cond    = C_CLR;
        w.target  = U_IDLE;
      end
      U_IDLE: begin
        w.in_rdy = 1'b1;
        w.ant_op = A_READ_IN;
        w.cond   = C_DISPATCH;
        w.target = U_IDLE;
      end
      U_RULE: begin
        w.rule_op = R_LOAD;
        w.target  = U_IDLE;
      end
      U_CELL: begin
        w.grid_op = G_ITEM;
        w.target  = U_IDLE;
      end
      U_PLACE: begin
        w.ant_op = A_PLACE;
        w.target = U_IDLE;
      end
      U_POS: begin
        w.pos_ld = 1'b1;
        w.cond   = C_ANT_OK;
        w.target = U_NBR;
      end
      U_NBR: begin
        w.grid_op = G_NBR_RD;
        w.cond    = C_KLAST;
        w.target  = U_LAST;
      end
      U_LAST: begin
        w.rule_op = R_READ;
        w.target  = U_MOVE;
      end
      U_MOVE: begin
        w.grid_op = G_TOGGLE;
        w.ant_op  = A_MOVE;
        w.out_ld  = 1'b1;
        w.cond    = C_OUT_FREE;
        w.target  = U_IDLE;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(input cmd_t c);
    upc_t u;
    unique case (c)
      CMD_RULE:  u = U_RULE;
      CMD_CELL:  u = U_CELL;
      CMD_PLACE: u = U_PLACE;
      CMD_STEP:  u = U_POS;
      default:   u = U_IDLE;
    endcase
    return u;
  endfunction

  // Row and column offsets of a move, coded 0, 1, 2 for -1, 0, +1.
  function automatic logic [1:0] move_dr(input logic [MOVE_W-1:0] mv);
    logic [1:0] d;
    unique case (mv)
      3'd0, 3'd1, 3'd2: d = 2'd0;
      3'd3, 3'd4:       d = 2'd1;
      default:          d = 2'd2;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] move_dc(input logic [MOVE_W-1:0] mv);
    logic [1:0] d;
    unique case (mv)
      3'd0, 3'd3, 3'd5: d = 2'd0;
      3'd1, 3'd6:       d = 2'd1;
      default:          d = 2'd2;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/mtg_in_if.sv @@
// Input channel of the grid stepper: valid/ready handshake with the command item.
// Depends on nothing.
`timescale 1ns / 1ps

interface mtg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] ant_index;
  logic [8:0] rule_index;
  logic [2:0] rule_move;
  logic [5:0] row;
  logic [6:0] col;
  logic       cell_value;

  modport source (
    output valid, cmd, ant_index, rule_index, rule_move, row, col, cell_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, ant_index, rule_index, rule_move, row, col, cell_value,
    output ready
  );
endinterface

@@ hdl/mtg_out_if.sv @@
// Result channel of the grid stepper: valid/ready handshake with one step result.
// Depends on nothing.
`timescale 1ns / 1ps

interface mtg_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] stepped_ant;
  logic [5:0] flipped_row;
  logic [6:0] flipped_col;
  logic       new_cell;
  logic [8:0] neighbour_code;
  logic [2:0] chosen_move;
  logic [5:0] next_row;
  logic [6:0] next_col;

  modport source (
    output valid, stepped_ant, flipped_row, flipped_col, new_cell,
           neighbour_code, chosen_move, next_row, next_col,
    input  ready
  );
  modport sink (
    input  valid, stepped_ant, flipped_row, flipped_col, new_cell,
           neighbour_code, chosen_move, next_row, next_col,
    output ready
  );
endinterface

@@ hdl/mtg_ram.sv @@
// Generic single-port RAM with registered read data, used for all stores.
// Depends on nothing.
`timescale 1ns / 1ps

module mtg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ hdl/mtg_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mtg_pkg for the control word, status and micro-address types.
`timescale 1ns / 1ps

module mtg_seq
  import mtg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  upc_t  upc_r, upc_nxt;
  ctrl_t word;
  logic  hold;

  assign word = ucode(upc_r);

  always_comb begin
    hold    = 1'b0;
    upc_nxt = word.target;
    unique case (word.cond)
      C_GOTO:     upc_nxt = word.target;
      C_DISPATCH: upc_nxt = status.accept ? dispatch(status.cmd) : upc_r;
      C_CLR:      upc_nxt = status.clr_last ? word.target : upc_r;
      C_ANT_OK:   upc_nxt = status.ant_ok ? word.target : U_IDLE;
      C_KLAST:    upc_nxt = status.k_last ? word.target : upc_r;
      C_OUT_FREE: begin
        hold    = !status.out_free;
        upc_nxt = hold ? upc_r : word.target;
      end
      default:    upc_nxt = U_IDLE;
    endcase
  end

  // A step that waits for the result register issues no strobes.
  always_comb begin
    ctrl = word;
    if (hold) begin
      ctrl.grid_op = G_NONE;
      ctrl.rule_op = R_NONE;
      ctrl.ant_op  = A_NONE;
      ctrl.pos_ld  = 1'b0;
      ctrl.out_ld  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_CLEAR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ hdl/mtg_datapath.sv @@
// Datapath: item registers, grid, rule and ant-position memories, neighbour
// address walk, move logic and the result register. Uses mtg_pkg and mtg_ram.
`timescale 1ns / 1ps

module mtg_datapath
  import mtg_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS,
  parameter int ANTS = DEF_ANTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ctrl_t    ctrl,
  output status_t  status,
  mtg_in_if.sink   in_if,
  mtg_out_if.source out_if
);

  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLS);
  localparam int PW   = RW + CW;
  localparam int GD   = ROWS * COLS;
  localparam int GW   = $clog2(GD);
  localparam int AAW  = (ANTS > 1) ? $clog2(ANTS) : 1;
  localparam int RD   = ANTS * RULE_ENTRIES;
  localparam int RAW  = $clog2(RD);

  function automatic logic [RW-1:0] wrap_r(input logic [RW-1:0] p, input logic [1:0] d);
    logic [RW-1:0] q;
    priority if (d == 2'd0) begin
      q = (p == '0) ? RW'(ROWS - 1) : p - RW'(1);
    end else if (d == 2'd2) begin
      q = (p == RW'(ROWS - 1)) ? '0 : p + RW'(1);
    end else begin
      q = p;
    end
    return q;
  endfunction

  function automatic logic [CW-1:0] wrap_c(input logic [CW-1:0] p, input logic [1:0] d);
    logic [CW-1:0] q;
    priority if (d == 2'd0) begin
      q = (p == '0) ? CW'(COLS - 1) : p - CW'(1);
    end else if (d == 2'd2) begin
      q = (p == CW'(COLS - 1)) ? '0 : p + CW'(1);
    end else begin
      q = p;
    end
    return q;
  endfunction

  function automatic logic [GW-1:0] gaddr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return GW'(r) * GW'(COLS) + GW'(c);
  endfunction

  logic               accept;
  logic [AAW-1:0]     ant_r;
  logic [3:0]         ant_id_r;
  logic [CODE_W-1:0]  ridx_r;
  logic [MOVE_W-1:0]  rmove_r;
  logic [RW-1:0]      row_r;
  logic [CW-1:0]      col_r;
  logic               val_r;
  logic               ant_ok_r;
  logic               cell_ok_r;

  logic [GW-1:0]      clr_r;
  logic [RW-1:0]      prow_r;
  logic [CW-1:0]      pcol_r;
  logic [1:0]         dr_r, dc_r;
  logic               rd_pend_r;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [ANTS-1:0]    ant_vld_r;
  logic               vld_rd_r;

  logic               g_en, g_we, g_wdata, g_rdata;
  logic [GW-1:0]      g_addr;
  logic               r_en, r_we;
  logic [RAW-1:0]     r_addr;
  logic [MOVE_W-1:0]  r_rdata;
  logic               a_en, a_we;
  logic [AAW-1:0]     a_addr;
  logic [PW-1:0]      a_wdata, a_rdata;

  logic [MOVE_W-1:0]  mv;
  logic [RW-1:0]      nrow;
  logic [CW-1:0]      ncol;

  logic               out_valid_r;

  assign in_if.ready = ctrl.in_rdy;
  assign accept      = in_if.valid && ctrl.in_rdy;

  assign status.accept   = accept;
  assign status.cmd      = cmd_t'(in_if.cmd);
  assign status.clr_last = (clr_r == GW'(GD - 1));
  assign status.ant_ok   = ant_ok_r;
  assign status.k_last   = (dr_r == 2'd2) && (dc_r == 2'd2);
  assign status.out_free = !out_valid_r || out_if.ready;

  assign code_nxt = rd_pend_r ? {g_rdata, code_r[CODE_W-1:1]} : code_r;
  assign mv       = r_rdata;
  assign nrow     = wrap_r(prow_r, move_dr(mv));
  assign ncol     = wrap_c(pcol_r, move_dc(mv));

  always_ff @(posedge clk) begin
    if (accept) begin
      ant_r     <= AAW'(in_if.ant_index);
      ant_id_r  <= in_if.ant_index;
      ridx_r    <= in_if.rule_index;
      rmove_r   <= in_if.rule_move;
      row_r     <= RW'(in_if.row);
      col_r     <= CW'(in_if.col);
      val_r     <= in_if.cell_value;
      ant_ok_r  <= 32'(in_if.ant_index) < ANTS;
      cell_ok_r <= (32'(in_if.row) < ROWS) && (32'(in_if.col) < COLS);
    end
    if (ctrl.pos_ld) begin
      prow_r <= vld_rd_r ? a_rdata[PW-1:CW] : '0;
      pcol_r <= vld_rd_r ? a_rdata[CW-1:0] : '0;
    end
    code_r <= code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      dr_r      <= '0;
      dc_r      <= '0;
      rd_pend_r <= 1'b0;
      ant_vld_r <= '0;
      vld_rd_r  <= 1'b0;
    end else begin
      rd_pend_r <= (ctrl.grid_op == G_NBR_RD);
      if (ctrl.grid_op == G_CLEAR) begin
        clr_r <= clr_r + GW'(1);
      end
      if (ctrl.pos_ld) begin
        dr_r <= '0;
        dc_r <= '0;
      end else if (ctrl.grid_op == G_NBR_RD) begin
        if (dc_r == 2'd2) begin
          dc_r <= '0;
          dr_r <= dr_r + 2'd1;
        end else begin
          dc_r <= dc_r + 2'd1;
        end
      end
      if (ctrl.ant_op == A_READ_IN) begin
        vld_rd_r <= ant_vld_r[AAW'(in_if.ant_index)];
      end
      if (a_en && a_we) begin
        ant_vld_r[a_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    g_en    = 1'b0;
    g_we    = 1'b0;
    g_wdata = 1'b0;
    g_addr  = gaddr(prow_r, pcol_r);
    unique case (ctrl.grid_op)
      G_NONE: g_en = 1'b0;
      G_CLEAR: begin
        g_en   = 1'b1;
        g_we   = 1'b1;
        g_addr = clr_r;
      end
      G_ITEM: begin
        g_en    = cell_ok_r;
        g_we    = 1'b1;
        g_wdata = val_r;
        g_addr  = gaddr(row_r, col_r);
      end
      G_NBR_RD: begin
        g_en   = 1'b1;
        g_addr = gaddr(wrap_r(prow_r, dr_r), wrap_c(pcol_r, dc_r));
      end
      G_TOGGLE: begin
        g_en    = 1'b1;
        g_we    = 1'b1;
        g_wdata = ~code_r[4];
      end
      default: g_en = 1'b0;
    endcase
  end

  always_comb begin
    r_en   = 1'b0;
    r_we   = 1'b0;
    r_addr = RAW'(ant_r) * RAW'(RULE_ENTRIES) + RAW'(code_nxt);
    unique case (ctrl.rule_op)
      R_NONE: r_en = 1'b0;
      R_LOAD: begin
        r_en   = ant_ok_r;
        r_we   = 1'b1;
        r_addr = RAW'(ant_r) * RAW'(RULE_ENTRIES) + RAW'(ridx_r);
      end
      R_READ: r_en = 1'b1;
      default: r_en = 1'b0;
    endcase
  end

  always_comb begin
    a_en    = 1'b0;
    a_we    = 1'b0;
    a_addr  = ant_r;
    a_wdata = {nrow, ncol};
    unique case (ctrl.ant_op)
      A_NONE: a_en = 1'b0;
      A_READ_IN: begin
        a_en   = 1'b1;
        a_addr = AAW'(in_if.ant_index);
      end
      A_PLACE: begin
        a_en    = ant_ok_r && cell_ok_r;
        a_we    = 1'b1;
        a_wdata = {row_r, col_r};
      end
      A_MOVE: begin
        a_en = 1'b1;
        a_we = 1'b1;
      end
      default: a_en = 1'b0;
    endcase
  end

  mtg_ram #(.WIDTH(1), .DEPTH(GD)) u_grid (
    .clk(clk), .en(g_en), .we(g_we), .addr(g_addr), .wdata(g_wdata), .rdata(g_rdata)
  );

  mtg_ram #(.WIDTH(MOVE_W), .DEPTH(RD)) u_rule (
    .clk(clk), .en(r_en), .we(r_we), .addr(r_addr), .wdata(rmove_r), .rdata(r_rdata)
  );

  mtg_ram #(.WIDTH(PW), .DEPTH(ANTS)) u_ant (
    .clk(clk), .en(a_en), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata)
  );

  assign out_if.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      out_if.stepped_ant    <= ant_id_r;
      out_if.flipped_row    <= 6'(prow_r);
      out_if.flipped_col    <= 7'(pcol_r);
      out_if.new_cell       <= ~code_r[4];
      out_if.neighbour_code <= code_r;
      out_if.chosen_move    <= mv;
      out_if.next_row       <= 6'(nrow);
      out_if.next_col       <= 7'(ncol);
    end
  end

endmodule

@@ hdl/multi_turmite_grid_step.sv @@
// Top level of the multi-ant toroidal grid stepper: sequencer plus datapath.
// Depends on mtg_pkg, mtg_in_if, mtg_out_if, mtg_seq and mtg_datapath.
`timescale 1ns / 1ps

// After reset the block clears the grid one cell per cycle, all ROWS*COLS cells
// (8192 at the default size), and takes no item until that pass ends. A rule
// load, cell write or ant placement passes through the idle state that accepts
// it and then the store state. A step passes through the accepting idle state,
// the state that loads the ant position, the nine neighbour reads that the
// single-port grid memory serves one per cycle, the rule lookup and the toggle
// write. A finished result waits in an output register while the next item is
// accepted; a step stalls in its last state, the toggle write, only if the
// previous result has not yet been taken.
module multi_turmite_grid_step
  import mtg_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS,
  parameter int ANTS = DEF_ANTS
) (
  input  logic      clk,
  input  logic      rst_n,
  mtg_in_if.sink    in_if,
  mtg_out_if.source out_if
);

  ctrl_t   ctrl;
  status_t status;

  mtg_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mtg_datapath #(
    .ROWS(ROWS),
    .COLS(COLS),
    .ANTS(ANTS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .status (status),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for multi_turmite_grid_step: random and directed command items,
// with a class that tracks grid, rule tables and ant positions to predict each step result.
// Depends on mtg_pkg, mtg_in_if, mtg_out_if and the top level of the block.
`timescale 1ns / 1ps

module testbench;
  import mtg_pkg::*;

  typedef struct {
    cmd_t       cmd;
    logic [3:0] ant;
    logic [8:0] rule_index;
    logic [2:0] rule_move;
    logic [5:0] row;
    logic [6:0] col;
    logic       cell_value;
  } cmd_item_t;

  typedef struct {
    logic [3:0] stepped_ant;
    logic [5:0] flipped_row;
    logic [6:0] flipped_col;
    logic       new_cell;
    logic [8:0] neighbour_code;
    logic [2:0] chosen_move;
    logic [5:0] next_row;
    logic [6:0] next_col;
  } step_result_t;

  class ant_walk_book;
    bit           grid[DEF_ROWS][DEF_COLS];
    bit [2:0]     rules[DEF_ANTS][RULE_ENTRIES];
    bit           rule_set[DEF_ANTS][RULE_ENTRIES];
    bit [5:0]     rows[DEF_ANTS];
    bit [6:0]     cols[DEF_ANTS];
    step_result_t pending_steps[$];
    int           mismatches;
    int           row_ofs[8] = '{0, 0, 0, 1, 1, 2, 2, 2};
    int           col_ofs[8] = '{0, 1, 2, 0, 2, 0, 1, 2};

    function int wrap(int p, int d, int n);
      return (p + n + d - 1) % n;
    endfunction

    function bit [8:0] code_for(int a);
      bit [8:0] code;
      for (int k = 0; k < 9; k++)
        code[k] = grid[wrap(rows[a], k / 3, DEF_ROWS)][wrap(cols[a], k % 3, DEF_COLS)];
      return code;
    endfunction

    function void apply_item(cmd_item_t it);
      step_result_t res;
      int a;
      a = it.ant;
      case (it.cmd)
        CMD_CELL: begin
          if (it.row < DEF_ROWS && it.col < DEF_COLS) grid[it.row][it.col] = it.cell_value;
        end
        CMD_RULE: begin
          if (a < DEF_ANTS) begin
            rules[a][it.rule_index] = it.rule_move;
            rule_set[a][it.rule_index] = 1'b1;
          end
        end
        CMD_PLACE: begin
          if (a < DEF_ANTS && it.row < DEF_ROWS && it.col < DEF_COLS) begin
            rows[a] = it.row;
            cols[a] = it.col;
          end
        end
        CMD_STEP: begin
          if (a < DEF_ANTS) begin
            res.stepped_ant    = it.ant;
            res.flipped_row    = rows[a];
            res.flipped_col    = cols[a];
            res.neighbour_code = code_for(a);
            res.chosen_move    = rules[a][res.neighbour_code];
            res.new_cell       = !grid[rows[a]][cols[a]];
            grid[rows[a]][cols[a]] = res.new_cell;
            res.next_row = 6'(wrap(rows[a], row_ofs[res.chosen_move], DEF_ROWS));
            res.next_col = 7'(wrap(cols[a], col_ofs[res.chosen_move], DEF_COLS));
            rows[a] = res.next_row;
            cols[a] = res.next_col;
            pending_steps.push_back(res);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_step(step_result_t got);
      step_result_t want;
      if (pending_steps.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual ant %0d", $time,
                 got.stepped_ant);
        return;
      end
      want = pending_steps.pop_front();
      compare_field("stepped_ant", 32'(want.stepped_ant), 32'(got.stepped_ant));
      compare_field("flipped_row", 32'(want.flipped_row), 32'(got.flipped_row));
      compare_field("flipped_col", 32'(want.flipped_col), 32'(got.flipped_col));
      compare_field("new_cell", 32'(want.new_cell), 32'(got.new_cell));
      compare_field("neighbour_code", 32'(want.neighbour_code), 32'(got.neighbour_code));
      compare_field("chosen_move", 32'(want.chosen_move), 32'(got.chosen_move));
      compare_field("next_row", 32'(want.next_row), 32'(got.next_row));
      compare_field("next_col", 32'(want.next_col), 32'(got.next_col));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   sent;

  ant_walk_book book;

  mtg_in_if  in_ch ();
  mtg_out_if out_ch ();

  multi_turmite_grid_step u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit calm();
    return sent >= 400 && sent < 550;
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= calm() || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    step_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.stepped_ant    = out_ch.stepped_ant;
      got.flipped_row    = out_ch.flipped_row;
      got.flipped_col    = out_ch.flipped_col;
      got.new_cell       = out_ch.new_cell;
      got.neighbour_code = out_ch.neighbour_code;
      got.chosen_move    = out_ch.chosen_move;
      got.next_row       = out_ch.next_row;
      got.next_col       = out_ch.next_col;
      book.check_step(got);
    end
  end

  function automatic cmd_item_t noise_item();
    cmd_item_t it;
    it.cmd        = cmd_t'($urandom_range(0, 3));
    it.ant        = 4'($urandom_range(0, 15));
    it.rule_index = 9'($urandom_range(0, 511));
    it.rule_move  = 3'($urandom_range(0, 7));
    it.row        = 6'($urandom_range(0, 63));
    it.col        = 7'($urandom_range(0, 127));
    it.cell_value = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // The input side idles only in cycles where the block is ready for an item.
  task automatic send(input cmd_item_t it);
    @(negedge clk);
    while (!calm() && in_ch.ready === 1'b1 && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= it.cmd;
    in_ch.ant_index  <= it.ant;
    in_ch.rule_index <= it.rule_index;
    in_ch.rule_move  <= it.rule_move;
    in_ch.row        <= it.row;
    in_ch.col        <= it.col;
    in_ch.cell_value <= it.cell_value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.apply_item(it);
    sent++;
  endtask

  task automatic place_item(input cmd_t cmd, input int a, input int r, input int c,
                            input bit v);
    cmd_item_t it;
    it = noise_item();
    it.cmd        = cmd;
    it.ant        = 4'(a);
    it.row        = 6'(r);
    it.col        = 7'(c);
    it.cell_value = v;
    send(it);
  endtask

  // A step is always preceded by a rule load when the ant's entry for the
  // neighbourhood it will see has never been written.
  task automatic step_ant(input int a, input bit fixed, input bit [2:0] mv);
    cmd_item_t it;
    bit [8:0]  code;
    code = book.code_for(a);
    if (fixed || !book.rule_set[a][code]) begin
      it = noise_item();
      it.cmd        = CMD_RULE;
      it.ant        = 4'(a);
      it.rule_index = code;
      it.rule_move  = fixed ? mv : 3'($urandom_range(0, 7));
      send(it);
    end
    it = noise_item();
    it.cmd = CMD_STEP;
    it.ant = 4'(a);
    send(it);
  endtask

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    cmd_item_t it;
    int a;
    int pick;
    book = new();
    sent = 0;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_RULE;
    in_ch.ant_index = '0;
    in_ch.rule_index = '0;
    in_ch.rule_move = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.cell_value = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    place_item(CMD_CELL, 0, 63, 127, 1'b1);
    place_item(CMD_CELL, 0, 0, 1, 1'b1);
    place_item(CMD_CELL, 0, 1, 0, 1'b1);
    place_item(CMD_PLACE, 0, 0, 0, 1'b0);
    for (int m = 0; m < 8; m++) step_ant(0, 1'b1, 3'(m));
    place_item(CMD_PLACE, 15, 63, 127, 1'b0);
    step_ant(15, 1'b1, 3'd7);
    step_ant(15, 1'b1, 3'd0);

    while (sent < 850) begin
      it = noise_item();
      a = $urandom_range(0, 15);
      it.ant = 4'(a);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        it.cmd = CMD_RULE;
        send(it);
      end else if (pick < 28) begin
        it.cmd = CMD_CELL;
        if ($urandom_range(0, 1)) begin
          it.row = book.rows[a] + 6'($urandom_range(0, 2)) - 6'd1;
          it.col = book.cols[a] + 7'($urandom_range(0, 2)) - 7'd1;
        end
        send(it);
      end else if (pick < 36) begin
        it.cmd = CMD_PLACE;
        if ($urandom_range(0, 3) == 0) begin
          it.row = $urandom_range(0, 1) ? 6'd63 : 6'd0;
          it.col = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        end
        send(it);
      end else begin
        step_ant(a, 1'b0, 3'd0);
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (book.pending_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.mismatches == 0 && book.pending_steps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mtg_pkg.sv
hdl/mtg_in_if.sv
hdl/mtg_out_if.sv
hdl/mtg_ram.sv
hdl/mtg_seq.sv
hdl/mtg_datapath.sv
hdl/multi_turmite_grid_step.sv
tb/testbench.sv
